>>> rtl/trapi_pkg.sv
// Types, constants and control store for the trapezoid integrator.
package trapi_pkg;

    localparam int MUL_BITS = 32;
    localparam int DIV_BITS = 32;
    localparam int X_BITS   = 34;
    localparam int ACC_BITS = 64;
    localparam int PROD_BITS = 3 * MUL_BITS;

    localparam logic [ACC_BITS-1:0] MAX64 = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic [ACC_BITS-1:0] MIN64 = {1'b1, {(ACC_BITS-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_STEP,
        ST_F0_SET,
        ST_F0_LO,
        ST_F0_HI,
        ST_F0_ACC,
        ST_F0_PUT,
        ST_XADV,
        ST_F1_SET,
        ST_F1_LO,
        ST_F1_HI,
        ST_F1_ACC,
        ST_F1_PUT,
        ST_T_SET,
        ST_T_LO,
        ST_T_HI,
        ST_T_ACC,
        ST_TERM,
        ST_ACC,
        ST_DONE,
        ST_RET
    } t_step;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_STEP,
        OP_MSETF,
        OP_MSETT,
        OP_MLO,
        OP_MHI,
        OP_MACC,
        OP_FA,
        OP_FB,
        OP_XADV,
        OP_TERM,
        OP_ACC,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_IN,
        JC_ZERO_N,
        JC_DIV_MORE,
        JC_CNT_MORE,
        JC_OUT_BUSY
    } t_jc;

    typedef struct packed {
        t_op   op;
        t_jc   jc;
        t_step target;
    } t_uword;

    function automatic t_uword f_ucode(input t_step pc);
        t_uword uw;
        uw = '{op: OP_NOP, jc: JC_ALWAYS, target: ST_IDLE};
        case (pc)
            ST_IDLE:   uw = '{op: OP_LOAD,  jc: JC_NO_IN,    target: ST_IDLE};
            ST_CHECK:  uw = '{op: OP_NOP,   jc: JC_ZERO_N,   target: ST_DONE};
            ST_DIV:    uw = '{op: OP_DIV,   jc: JC_DIV_MORE, target: ST_DIV};
            ST_STEP:   uw = '{op: OP_STEP,  jc: JC_NEXT,     target: ST_IDLE};
            ST_F0_SET: uw = '{op: OP_MSETF, jc: JC_NEXT,     target: ST_IDLE};
            ST_F0_LO:  uw = '{op: OP_MLO,   jc: JC_NEXT,     target: ST_IDLE};
            ST_F0_HI:  uw = '{op: OP_MHI,   jc: JC_NEXT,     target: ST_IDLE};
            ST_F0_ACC: uw = '{op: OP_MACC,  jc: JC_NEXT,     target: ST_IDLE};
            ST_F0_PUT: uw = '{op: OP_FA,    jc: JC_NEXT,     target: ST_IDLE};
            ST_XADV:   uw = '{op: OP_XADV,  jc: JC_NEXT,     target: ST_IDLE};
            ST_F1_SET: uw = '{op: OP_MSETF, jc: JC_NEXT,     target: ST_IDLE};
            ST_F1_LO:  uw = '{op: OP_MLO,   jc: JC_NEXT,     target: ST_IDLE};
            ST_F1_HI:  uw = '{op: OP_MHI,   jc: JC_NEXT,     target: ST_IDLE};
            ST_F1_ACC: uw = '{op: OP_MACC,  jc: JC_NEXT,     target: ST_IDLE};
            ST_F1_PUT: uw = '{op: OP_FB,    jc: JC_NEXT,     target: ST_IDLE};
            ST_T_SET:  uw = '{op: OP_MSETT, jc: JC_NEXT,     target: ST_IDLE};
            ST_T_LO:   uw = '{op: OP_MLO,   jc: JC_NEXT,     target: ST_IDLE};
            ST_T_HI:   uw = '{op: OP_MHI,   jc: JC_NEXT,     target: ST_IDLE};
            ST_T_ACC:  uw = '{op: OP_MACC,  jc: JC_NEXT,     target: ST_IDLE};
            ST_TERM:   uw = '{op: OP_TERM,  jc: JC_NEXT,     target: ST_IDLE};
            ST_ACC:    uw = '{op: OP_ACC,   jc: JC_CNT_MORE, target: ST_XADV};
            ST_DONE:   uw = '{op: OP_OUT,   jc: JC_OUT_BUSY, target: ST_DONE};
            ST_RET:    uw = '{op: OP_NOP,   jc: JC_ALWAYS,   target: ST_IDLE};
            default:   uw = '{op: OP_NOP,   jc: JC_ALWAYS,   target: ST_IDLE};
        endcase
        return uw;
    endfunction

endpackage

>>> rtl/trapezoid_integrator_core.sv
// Trapezoidal-rule integrator of f(x) = x/2*(x+5), microcoded sequencer and datapath.
//
// One beat in gives one beat out. The next item is accepted only once the program is back
// at idle. A one-bit-per-cycle restoring divider forms the step, and each slice then runs
// 12 steps of the control program, which use the single shared 32x32 multiplier to form
// one f(x) product and one slice product, each as two partial products; a zero slice count
// skips the divider and the slices. The result sits in an output register; a new item is
// accepted while it waits, and the program holds at its last step only if a second result
// is ready first.
module trapezoid_integrator_core
    import trapi_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_start_point,
    input  logic signed [31:0] i_stop_point,
    input  logic        [15:0] i_point_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_integral,
    output logic               o_overflow
);

    localparam int EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int BIT_W    = $clog2(DIV_BITS);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(DIV_BITS - 1);
    localparam logic [X_BITS-1:0] FIVE_FX = X_BITS'(5 * (1 << FRAC_BITS));

    t_step                 r_pc;
    t_step                 n_pc;
    t_uword                w_uw;
    logic                  w_take;
    logic                  w_in_fire;

    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] r_den;
    logic [COUNT_BITS-1:0] r_rem;
    logic [DIV_BITS-1:0]   r_quo;
    logic                  r_qneg;
    logic [BIT_W-1:0]      r_bit;
    logic [X_BITS-1:0]     r_step;
    logic [X_BITS-1:0]     r_x;
    logic [ACC_BITS-1:0]   r_fa;
    logic [ACC_BITS-1:0]   r_fb;
    logic [ACC_BITS-1:0]   r_term;
    logic [ACC_BITS-1:0]   r_sum;
    logic                  r_ovf;
    logic [2*MUL_BITS-1:0] r_ma;
    logic [MUL_BITS-1:0]   r_mb;
    logic                  r_mneg;
    logic [2*MUL_BITS-1:0] r_pp;
    logic [PROD_BITS-1:0]  r_prod;
    logic                  r_out_valid;
    logic [ACC_BITS-1:0]   r_integral;
    logic                  r_overflow;

    logic [EXT_BITS-1:0]   w_cnt_ext;
    logic [COUNT_BITS-1:0] w_n;
    logic [32:0]           w_diff;
    logic [DIV_BITS-1:0]   w_diff_mag;
    logic [COUNT_BITS:0]   w_div_sh;
    logic [COUNT_BITS:0]   w_div_sub;
    logic                  w_div_ge;
    logic [X_BITS-1:0]     w_xoff;
    logic [X_BITS-1:0]     w_x_mag;
    logic [X_BITS-1:0]     w_xoff_mag;
    logic [ACC_BITS:0]     w_fsum;
    logic [ACC_BITS:0]     w_fsum_mag;
    logic [X_BITS-1:0]     w_step_mag;
    logic [MUL_BITS-1:0]   w_mul_a;
    logic [2*MUL_BITS-1:0] w_mul_p;
    logic [PROD_BITS-1:0]  w_sat_mag;
    logic                  w_sat_big;
    logic                  w_sat_ovf;
    logic [ACC_BITS-1:0]   w_sat_val;
    logic [ACC_BITS:0]     w_acc;
    logic                  w_acc_ovf;
    logic [ACC_BITS-1:0]   w_acc_val;

    assign o_in_ready = (r_pc == ST_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_comb begin
        w_uw = f_ucode(r_pc);
    end

    always_comb begin
        case (w_uw.jc)
            JC_NEXT:     w_take = 1'b0;
            JC_ALWAYS:   w_take = 1'b1;
            JC_NO_IN:    w_take = !w_in_fire;
            JC_ZERO_N:   w_take = (r_cnt == '0);
            JC_DIV_MORE: w_take = (r_bit != BIT_LAST);
            JC_CNT_MORE: w_take = (r_cnt != '0);
            JC_OUT_BUSY: w_take = r_out_valid;
            default:     w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uw.target : t_step'(5'(r_pc + 5'd1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign w_cnt_ext  = EXT_BITS'(i_point_count);
    assign w_n        = w_cnt_ext[COUNT_BITS-1:0];
    assign w_diff     = {i_stop_point[31], i_stop_point} - {i_start_point[31], i_start_point};
    assign w_diff_mag = w_diff[32] ? DIV_BITS'(33'd0 - w_diff) : w_diff[DIV_BITS-1:0];

    assign w_div_sh  = {r_rem, r_quo[DIV_BITS-1]};
    assign w_div_ge  = (w_div_sh >= {1'b0, r_den});
    assign w_div_sub = w_div_sh - {1'b0, r_den};

    assign w_xoff     = r_x + FIVE_FX;
    assign w_x_mag    = r_x[X_BITS-1] ? (X_BITS'(0) - r_x) : r_x;
    assign w_xoff_mag = w_xoff[X_BITS-1] ? (X_BITS'(0) - w_xoff) : w_xoff;
    assign w_step_mag = r_step[X_BITS-1] ? (X_BITS'(0) - r_step) : r_step;

    assign w_fsum     = {r_fa[ACC_BITS-1], r_fa} + {r_fb[ACC_BITS-1], r_fb};
    assign w_fsum_mag = w_fsum[ACC_BITS] ? ((ACC_BITS+1)'(0) - w_fsum) : w_fsum;

    assign w_mul_a = (w_uw.op == OP_MHI) ? r_ma[2*MUL_BITS-1:MUL_BITS] : r_ma[MUL_BITS-1:0];
    assign w_mul_p = w_mul_a * r_mb;

    always_comb begin
        if (w_uw.op == OP_TERM) begin
            w_sat_mag = r_prod >> (FRAC_BITS + 1);
        end else begin
            w_sat_mag = r_prod >> 1;
        end
        w_sat_big = |w_sat_mag[PROD_BITS-1:ACC_BITS];
        if (r_mneg) begin
            w_sat_ovf = w_sat_big || (w_sat_mag[ACC_BITS-1] && (|w_sat_mag[ACC_BITS-2:0]));
        end else begin
            w_sat_ovf = w_sat_big || w_sat_mag[ACC_BITS-1];
        end
        if (w_sat_ovf) begin
            w_sat_val = r_mneg ? MIN64 : MAX64;
        end else if (r_mneg) begin
            w_sat_val = ACC_BITS'(0) - w_sat_mag[ACC_BITS-1:0];
        end else begin
            w_sat_val = w_sat_mag[ACC_BITS-1:0];
        end
    end

    always_comb begin
        w_acc     = {r_sum[ACC_BITS-1], r_sum} + {r_term[ACC_BITS-1], r_term};
        w_acc_ovf = (w_acc[ACC_BITS] != w_acc[ACC_BITS-1]);
        if (w_acc_ovf) begin
            w_acc_val = w_acc[ACC_BITS] ? MIN64 : MAX64;
        end else begin
            w_acc_val = w_acc[ACC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            OP_LOAD: begin
                if (w_in_fire) begin
                    r_cnt  <= w_n;
                    r_den  <= w_n;
                    r_rem  <= '0;
                    r_quo  <= w_diff_mag;
                    r_qneg <= w_diff[32];
                    r_bit  <= '0;
                    r_x    <= {{(X_BITS-32){i_start_point[31]}}, i_start_point};
                    r_sum  <= '0;
                    r_ovf  <= 1'b0;
                end
            end
            OP_DIV: begin
                r_rem <= w_div_ge ? w_div_sub[COUNT_BITS-1:0] : w_div_sh[COUNT_BITS-1:0];
                r_quo <= {r_quo[DIV_BITS-2:0], w_div_ge};
                r_bit <= r_bit + BIT_W'(1);
            end
            OP_STEP: begin
                r_step <= r_qneg ? (X_BITS'(0) - X_BITS'(r_quo)) : X_BITS'(r_quo);
            end
            OP_MSETF: begin
                r_ma   <= (2*MUL_BITS)'(w_x_mag[MUL_BITS-1:0]);
                r_mb   <= w_xoff_mag[MUL_BITS-1:0];
                r_mneg <= r_x[X_BITS-1] ^ w_xoff[X_BITS-1];
            end
            OP_MSETT: begin
                r_ma   <= w_fsum_mag[2*MUL_BITS-1:0];
                r_mb   <= w_step_mag[MUL_BITS-1:0];
                r_mneg <= w_fsum[ACC_BITS] ^ r_step[X_BITS-1];
            end
            OP_MLO: begin
                r_pp <= w_mul_p;
            end
            OP_MHI: begin
                r_prod <= PROD_BITS'(r_pp);
                r_pp   <= w_mul_p;
            end
            OP_MACC: begin
                r_prod <= r_prod + {r_pp, {MUL_BITS{1'b0}}};
            end
            OP_FA: begin
                r_fa <= w_sat_val;
                r_ovf <= r_ovf | w_sat_ovf;
            end
            OP_FB: begin
                r_fb <= w_sat_val;
                r_ovf <= r_ovf | w_sat_ovf;
            end
            OP_XADV: begin
                r_x   <= r_x + r_step;
                r_cnt <= r_cnt - COUNT_BITS'(1);
            end
            OP_TERM: begin
                r_term <= w_sat_val;
                r_ovf  <= r_ovf | w_sat_ovf;
            end
            OP_ACC: begin
                r_sum <= w_acc_val;
                r_ovf <= r_ovf | w_acc_ovf;
                r_fa  <= r_fb;
            end
            OP_OUT: begin
                if (!r_out_valid) begin
                    r_integral <= r_sum;
                    r_overflow <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uw.op == OP_OUT && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_integral  = r_integral;
    assign o_overflow  = r_overflow;

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_IDLE && !w_in_fire) |=> (r_pc == ST_IDLE))
        else $error("sequencer left idle without an input beat");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_pc) == ST_DONE))
        else $error("result beat raised outside the final step");

    a_slice_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_XADV) |-> (r_cnt != '0))
        else $error("slice advance with no slices left");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_CHECK && r_cnt == '0) |=> (r_pc == ST_DONE && r_sum == '0 && !r_ovf))
        else $error("zero slice count did not yield a clean zero");

endmodule

>>> sim/trapezoid_integrator_core_tb.sv
// Self-checking testbench for trapezoid_integrator_core: directed and random intervals.
`timescale 1ns / 100ps

module trapezoid_integrator_core_tb
    import trapi_pkg::*;
();

    localparam int FRAC        = 16;
    localparam int CNT_W       = 16;
    localparam int RAND_ITEMS  = 1500;
    localparam int HOLD_CYCLES = 3000;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [31:0]  S32_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0]  S32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]  ONE      = 32'sd65536;
    localparam logic signed [63:0]  FIVE_Q   = 64'sd5 <<< FRAC;
    localparam logic signed [127:0] WIDE_MAX = {65'd0, {63{1'b1}}};
    localparam logic signed [127:0] WIDE_MIN = {{65{1'b1}}, 63'd0};

    typedef struct packed {
        logic signed [63:0] area;
        logic               sat;
    } t_area;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [CNT_W-1:0]   cnt;
        logic               known;
        t_area              want;
    } t_probe;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_start_point = '0;
    logic signed [31:0] i_stop_point  = '0;
    logic [15:0]        i_point_count = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic signed [63:0] o_integral;
    logic               o_overflow;

    t_area pending_areas[$];
    int    bad_count    = 0;
    int    results_seen = 0;
    int    tx_idle_pct  = 0;
    int    rx_stall_pct = 0;

    t_probe probes [18] = '{
        '{32'sd0,          32'sd0,          16'd0,     1'b1, '{64'sd0, 1'b0}},
        '{S32_MAX,         S32_MIN,         16'd0,     1'b1, '{64'sd0, 1'b0}},
        '{S32_MIN,         S32_MIN,         16'd9,     1'b1, '{64'sd0, 1'b0}},
        '{5 * ONE,         5 * ONE,         16'd7,     1'b1, '{64'sd0, 1'b0}},
        '{S32_MIN,         S32_MAX,         16'd1,     1'b1, '{MAX64,  1'b1}},
        '{S32_MAX,         S32_MIN,         16'd1,     1'b1, '{MIN64,  1'b1}},
        '{32'sd0,          ONE,             16'd1,     1'b0, '0},
        '{-5 * ONE,        32'sd0,          16'd4,     1'b0, '0},
        '{3 * ONE,         -3 * ONE,        16'd6,     1'b0, '0},
        '{32'sd1,          32'sd0,          16'd2,     1'b0, '0},
        '{-32'sd1,         32'sd0,          16'd3,     1'b0, '0},
        '{32'sd0,          32'sd100,        16'd7,     1'b0, '0},
        '{S32_MIN,         32'sd0,          16'd2,     1'b0, '0},
        '{32'sd0,          S32_MAX,         16'd3,     1'b0, '0},
        '{-100 * ONE,      100 * ONE,       16'd50,    1'b0, '0},
        '{32'sh5555_5555,  32'shAAAA_AAAA,  16'd5,     1'b0, '0},
        '{S32_MIN,         S32_MAX,         16'd1000,  1'b0, '0},
        '{32'sd0,          10 * ONE,        16'hFFFF,  1'b0, '0}
    };

    trapezoid_integrator_core #(
        .FRAC_BITS  (FRAC),
        .COUNT_BITS (CNT_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_start_point (i_start_point),
        .i_stop_point  (i_stop_point),
        .i_point_count (i_point_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_integral    (o_integral),
        .o_overflow    (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [127:0] shift_to_zero(input logic signed [127:0] w,
                                                           input int sh);
        return (w < 0) ? -((-w) >>> sh) : (w >>> sh);
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [127:0] w,
                                                   inout logic sat);
        if (w > WIDE_MAX) begin
            sat = 1'b1;
            return WIDE_MAX[63:0];
        end
        if (w < WIDE_MIN) begin
            sat = 1'b1;
            return WIDE_MIN[63:0];
        end
        return w[63:0];
    endfunction

    function automatic logic signed [63:0] quad_q(input logic signed [63:0] x, inout logic sat);
        logic signed [127:0] prod;
        prod = 128'(x) * (128'(x) + 128'(FIVE_Q));
        return clamp64(shift_to_zero(prod, 1), sat);
    endfunction

    function automatic t_area integrate(input logic signed [31:0] lo,
                                        input logic signed [31:0] hi,
                                        input logic [CNT_W-1:0]   cnt);
        t_area               res;
        logic signed [63:0]  x_lo, x_hi, xi, step, fa, fb, term, acc;
        logic signed [127:0] wide;
        logic                sat;
        x_lo = 64'(lo);
        x_hi = 64'(hi);
        acc  = '0;
        sat  = 1'b0;
        if (cnt != 0) begin
            step = (x_hi - x_lo) / $signed({48'd0, cnt});
            fa   = quad_q(x_lo, sat);
            for (int i = 1; i <= cnt; i++) begin
                xi   = x_lo + step * 64'(i);
                fb   = quad_q(xi, sat);
                wide = 128'(fa) * 128'(step) + 128'(fb) * 128'(step);
                term = clamp64(shift_to_zero(wide, FRAC + 1), sat);
                wide = 128'(acc) + 128'(term);
                acc  = clamp64(wide, sat);
                fa   = fb;
            end
        end
        res.area = acc;
        res.sat  = sat;
        return res;
    endfunction

    task automatic feed_interval(input logic signed [31:0] lo, input logic signed [31:0] hi,
                                 input logic [CNT_W-1:0] cnt, input logic known,
                                 input t_area want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_start_point <= lo;
        i_stop_point  <= hi;
        i_point_count <= cnt;
        do @(posedge i_clk); while (!o_in_ready);
        pending_areas.push_back(known ? want : integrate(lo, hi, cnt));
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_area want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_areas.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected beat: integral %0d overflow %0b",
                             o_integral, o_overflow);
            end else begin
                want = pending_areas.pop_front();
                if (o_integral !== want.area || o_overflow !== want.sat) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("mismatch: integral exp %0d got %0d, overflow exp %0b got %0b",
                                 want.area, o_integral, want.sat, o_overflow);
                end
            end
        end
    end

    initial begin
        int hold_left;
        int next_hold;
        hold_left = 0;
        next_hold = 100;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && results_seen >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold += 800;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        logic signed [31:0] lo, hi;
        logic [CNT_W-1:0]   cnt;
        int                 pick;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (probes[k])
            feed_interval(probes[k].lo, probes[k].hi, probes[k].cnt, probes[k].known,
                          probes[k].want);

        for (int k = 0; k < RAND_ITEMS; k++) begin
            case (k / (RAND_ITEMS / 4))
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 63;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 63;
                end
                default: begin
                    tx_idle_pct  = 36;
                    rx_stall_pct = 36;
                end
            endcase

            pick = $urandom_range(99);
            if (pick < 40) begin
                lo = int'($urandom_range(0, 128 * 65536)) - 64 * 65536;
                hi = lo + int'($urandom_range(0, 128 * 65536)) - 64 * 65536;
            end else if (pick < 60) begin
                lo = $urandom;
                hi = $urandom;
            end else if (pick < 75) begin
                lo = $urandom;
                hi = lo + int'($urandom_range(0, 1 << 20)) - (1 << 19);
            end else if (pick < 85) begin
                lo = $urandom;
                hi = lo;
            end else begin
                lo = $urandom_range(1) ? S32_MIN : S32_MAX;
                hi = $urandom_range(1) ? ~lo : $urandom;
            end

            pick = $urandom_range(99);
            if (pick < 8)
                cnt = '0;
            else if (pick < 70)
                cnt = CNT_W'($urandom_range(1, 16));
            else if (pick < 95)
                cnt = CNT_W'($urandom_range(17, 64));
            else
                cnt = CNT_W'($urandom_range(65, 400));

            feed_interval(lo, hi, cnt, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_areas.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (bad_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
